// ----- src/owps_pkg.sv -----
// shared types and constants for the one-wire pulse-width sender
// no dependencies
`default_nettype none

package owps_pkg;

    localparam int CMD_BITS      = 16;
    localparam int BIT_CNT_W     = $clog2(CMD_BITS + 1);
    localparam int TICK_W        = 16;
    localparam int VALUE_W       = 17;
    localparam int KIND_W        = 2;
    localparam int CFG_IDX_W     = 3;

    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PLAY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VOLUME = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LEAD_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LONG      = 3'd5;

    localparam logic [TICK_W-1:0] RST_LEAD_HIGH = 16'd6000;
    localparam logic [TICK_W-1:0] RST_LEAD_LOW  = 16'd6000;
    localparam logic [TICK_W-1:0] RST_GAP_HIGH  = 16'd3000;
    localparam logic [TICK_W-1:0] RST_GAP_LOW   = 16'd6000;
    localparam logic [TICK_W-1:0] RST_SHORT     = 16'd65;
    localparam logic [TICK_W-1:0] RST_LONG      = 16'd195;

    localparam logic [CMD_BITS-1:0] VOLUME_BASE = 16'hFFE0;
    localparam logic [3:0]          VOLUME_MAX  = 4'd15;

    typedef struct packed {
        logic [TICK_W-1:0] lead_high;
        logic [TICK_W-1:0] lead_low;
        logic [TICK_W-1:0] gap_high;
        logic [TICK_W-1:0] gap_low;
        logic [TICK_W-1:0] short_len;
        logic [TICK_W-1:0] long_len;
    } t_timing;

endpackage

`default_nettype wire

// ----- src/owps_in_if.sv -----
// command/tick input channel: valid, ready and item fields
// depends on owps_pkg
`default_nettype none

interface owps_in_if
    import owps_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] command_value;
    logic                      chip_busy_pin;

    modport source (output valid, kind, command_value, chip_busy_pin, input ready);
    modport sink   (input valid, kind, command_value, chip_busy_pin, output ready);
endinterface

`default_nettype wire

// ----- src/owps_out_if.sv -----
// result output channel: valid, ready and result fields
// no dependencies
`default_nettype none

interface owps_out_if;
    logic valid;
    logic ready;
    logic line_level;
    logic sending;
    logic accepted;
    logic chip_busy;

    modport source (output valid, line_level, sending, accepted, chip_busy, input ready);
    modport sink   (input valid, line_level, sending, accepted, chip_busy, output ready);
endinterface

`default_nettype wire

// ----- src/one_wire_pulse_width_sender.sv -----
// top level of the one-wire pulse-width sender: frame sequencer and result register
// depends on owps_pkg, owps_in_if, owps_out_if, owps_cfg_regs
//
// Drives the one-wire command line of a voice playback chip. A play or volume
// item starts a frame when idle; tick items (one per microsecond) advance it:
// lead high, lead low, eight bits, a high/low gap, eight more bits, then the
// line returns high. Each input item gives one result item showing the line
// level after it. One item is taken per clock while the result register is free
// or being read out: the frame state and the result register update in the same
// cycle, and a new item is accepted in the cycle a waiting result is read out.
`default_nettype none

module one_wire_pulse_width_sender
    import owps_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    owps_in_if.sink                   i_in,
    owps_out_if.source                o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [TICK_W-1:0]    i_cfg_data
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD_HIGH,
        PH_LEAD_LOW,
        PH_GAP_HIGH,
        PH_GAP_LOW,
        PH_BIT_HIGH,
        PH_BIT_LOW
    } t_phase;

    t_timing timing;

    owps_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_timing   (timing)
    );

    t_phase               r_phase,  n_phase;
    logic [CMD_BITS-1:0]  r_shift,  n_shift;
    logic [BIT_CNT_W-1:0] r_bits,   n_bits;
    logic [TICK_W-1:0]    r_timer,  n_timer;
    logic                 r_line,   n_line;
    logic                 r_out_valid;
    logic                 r_line_level, r_sending, r_accepted, r_chip_busy;

    logic                 in_xfer;
    logic                 accepted;
    logic [BIT_CNT_W-1:0] bits_inc;
    logic [CMD_BITS-1:0]  shift_next;
    logic [3:0]           vol_level;
    logic [CMD_BITS-1:0]  word;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;

    assign bits_inc   = r_bits + BIT_CNT_W'(1);
    assign shift_next = r_shift >> 1;

    // volume clamp to 0..15
    always_comb begin
        if (i_in.command_value < 0) begin
            vol_level = '0;
        end else if (i_in.command_value > VALUE_W'(signed'({1'b0, VOLUME_MAX}))) begin
            vol_level = VOLUME_MAX;
        end else begin
            vol_level = i_in.command_value[3:0];
        end
    end

    always_comb begin
        if (i_in.kind == KIND_PLAY) begin
            word = i_in.command_value[CMD_BITS-1:0];
        end else begin
            word = VOLUME_BASE | CMD_BITS'(vol_level);
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_shift  = r_shift;
        n_bits   = r_bits;
        n_timer  = r_timer;
        n_line   = r_line;
        accepted = 1'b0;
        if (in_xfer) begin
            case (i_in.kind)
                KIND_TICK: begin
                    if (r_phase != PH_IDLE) begin
                        if (r_timer <= TICK_W'(1)) begin
                            case (r_phase)
                                PH_LEAD_HIGH: begin
                                    n_phase = PH_LEAD_LOW;
                                    n_line  = 1'b0;
                                    n_timer = timing.lead_low;
                                end
                                PH_LEAD_LOW, PH_GAP_LOW: begin
                                    n_phase = PH_BIT_HIGH;
                                    n_line  = 1'b1;
                                    n_timer = r_shift[0] ? timing.long_len : timing.short_len;
                                end
                                PH_GAP_HIGH: begin
                                    n_phase = PH_GAP_LOW;
                                    n_line  = 1'b0;
                                    n_timer = timing.gap_low;
                                end
                                PH_BIT_HIGH: begin
                                    n_phase = PH_BIT_LOW;
                                    n_line  = 1'b0;
                                    n_timer = r_shift[0] ? timing.short_len : timing.long_len;
                                end
                                PH_BIT_LOW: begin
                                    n_shift = shift_next;
                                    n_bits  = bits_inc;
                                    if (bits_inc >= BIT_CNT_W'(CMD_BITS)) begin
                                        n_phase = PH_IDLE;
                                        n_line  = 1'b1;
                                        n_timer = '0;
                                        n_bits  = '0;
                                    end else if (bits_inc == BIT_CNT_W'(CMD_BITS / 2)) begin
                                        n_phase = PH_GAP_HIGH;
                                        n_line  = 1'b1;
                                        n_timer = timing.gap_high;
                                    end else begin
                                        n_phase = PH_BIT_HIGH;
                                        n_line  = 1'b1;
                                        n_timer = shift_next[0] ? timing.long_len
                                                                : timing.short_len;
                                    end
                                end
                                default: begin
                                    n_phase = PH_IDLE;
                                    n_line  = 1'b1;
                                    n_timer = '0;
                                    n_bits  = '0;
                                end
                            endcase
                        end else begin
                            n_timer = r_timer - TICK_W'(1);
                        end
                    end
                end
                KIND_PLAY, KIND_VOLUME: begin
                    if (r_phase == PH_IDLE) begin
                        // byte swap, high byte goes out first
                        n_shift  = {word[7:0], word[CMD_BITS-1:8]};
                        n_bits   = '0;
                        n_phase  = PH_LEAD_HIGH;
                        n_line   = 1'b1;
                        n_timer  = timing.lead_high;
                        accepted = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_shift     <= '0;
            r_bits      <= '0;
            r_timer     <= '0;
            r_line      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_shift <= n_shift;
            r_bits  <= n_bits;
            r_timer <= n_timer;
            r_line  <= n_line;
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_xfer) begin
            r_line_level <= n_line;
            r_sending    <= (n_phase != PH_IDLE);
            r_accepted   <= accepted;
            r_chip_busy  <= i_in.chip_busy_pin;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.line_level = r_line_level;
    assign o_out.sending    = r_sending;
    assign o_out.accepted   = r_accepted;
    assign o_out.chip_busy  = r_chip_busy;

endmodule

`default_nettype wire

// ----- src/owps_cfg_regs.sv -----
// timing configuration registers written through a plain write port
// depends on owps_pkg
`default_nettype none

module owps_cfg_regs
    import owps_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [TICK_W-1:0]    i_cfg_data,
    output t_timing                   o_timing
);

    t_timing r_timing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.lead_high <= RST_LEAD_HIGH;
            r_timing.lead_low  <= RST_LEAD_LOW;
            r_timing.gap_high  <= RST_GAP_HIGH;
            r_timing.gap_low   <= RST_GAP_LOW;
            r_timing.short_len <= RST_SHORT;
            r_timing.long_len  <= RST_LONG;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LEAD_HIGH: r_timing.lead_high <= i_cfg_data;
                REG_LEAD_LOW:  r_timing.lead_low  <= i_cfg_data;
                REG_GAP_HIGH:  r_timing.gap_high  <= i_cfg_data;
                REG_GAP_LOW:   r_timing.gap_low   <= i_cfg_data;
                REG_SHORT:     r_timing.short_len <= i_cfg_data;
                REG_LONG:      r_timing.long_len  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_timing = r_timing;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// self-checking testbench for one_wire_pulse_width_sender: drives tick and command
// transfers, predicts the line status of every transfer and compares each result
// depends on owps_pkg, owps_in_if, owps_out_if and the sender top level
module tb;
    import owps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT   = 50_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int SINK_HOLD     = 400;
    localparam int RANDOM_ROUNDS = 4;
    localparam int ROUND_ITEMS   = 50;
    localparam int FRAME_TICKS   = 56;

    typedef enum logic [2:0] {
        F_IDLE, F_LEAD_HIGH, F_LEAD_LOW, F_GAP_HIGH, F_GAP_LOW, F_BIT_HIGH, F_BIT_LOW
    } t_frame_phase;

    typedef enum {PACE_FULL, PACE_SRC_GAPS, PACE_SINK_STALLS, PACE_BOTH} t_pace;
    typedef enum {ROW_ITEM, ROW_REG} t_row;

    typedef struct {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        logic                      busy;
    } t_cmd_item;

    typedef struct packed {
        logic line_level;
        logic sending;
        logic accepted;
        logic chip_busy;
    } t_line_status;

    typedef struct {
        t_row                  op;
        t_cmd_item             it;
        int                    reps;
        bit                    has_exp;
        t_line_status          exp;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [TICK_W-1:0]     reg_data;
    } t_plan_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [TICK_W-1:0]    i_cfg_data;

    owps_in_if  in_if ();
    owps_out_if out_if ();

    one_wire_pulse_width_sender dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predicted sender state
    t_timing           timing;
    logic [CMD_BITS-1:0] m_word;
    t_frame_phase      m_phase;
    logic [4:0]        m_bits;
    logic [TICK_W-1:0] m_timer;
    logic              m_line;

    t_line_status status_q[$];
    t_plan_row    plan[$];

    int src_idle_pct;
    int sink_stall_pct;
    int sink_hold_request;
    int sink_hold_left;
    int cycles;
    int mismatches;
    int results_checked;
    int items_sent;
    int frames_started;
    int settings_used;
    bit hold_done;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, status_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stalls plus a long hold-off on request
    always @(negedge i_clk) begin
        if (sink_hold_request != 0) begin
            sink_hold_left = sink_hold_request;
            sink_hold_request = 0;
        end
        if (sink_hold_left > 0) begin
            sink_hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_line_status got;
        t_line_status want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = {out_if.line_level, out_if.sending, out_if.accepted, out_if.chip_busy};
            results_checked++;
            if (status_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d with nothing pending: got %4b",
                             results_checked, got);
            end else begin
                want = status_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected %4b, got %4b (line sending acc busy)",
                                 results_checked, want, got);
                end
            end
        end
    end

    function automatic void load_phase(t_frame_phase ph, logic lvl, logic [TICK_W-1:0] ticks);
        m_phase = ph;
        m_line  = lvl;
        m_timer = ticks;
    endfunction

    function automatic void load_bit_high();
        load_phase(F_BIT_HIGH, 1'b1, m_word[0] ? timing.long_len : timing.short_len);
    endfunction

    function automatic void advance_frame();
        case (m_phase)
            F_LEAD_HIGH: load_phase(F_LEAD_LOW, 1'b0, timing.lead_low);
            F_LEAD_LOW, F_GAP_LOW: load_bit_high();
            F_GAP_HIGH: load_phase(F_GAP_LOW, 1'b0, timing.gap_low);
            F_BIT_HIGH: load_phase(F_BIT_LOW, 1'b0, m_word[0] ? timing.short_len : timing.long_len);
            F_BIT_LOW: begin
                m_word = m_word >> 1;
                m_bits = m_bits + 5'd1;
                if (m_bits >= CMD_BITS) begin
                    load_phase(F_IDLE, 1'b1, '0);
                    m_bits = '0;
                end else if (m_bits == CMD_BITS / 2) begin
                    load_phase(F_GAP_HIGH, 1'b1, timing.gap_high);
                end else begin
                    load_bit_high();
                end
            end
            default: begin
                load_phase(F_IDLE, 1'b1, '0);
                m_bits = '0;
            end
        endcase
    endfunction

    function automatic t_line_status predict_line_status(t_cmd_item it);
        t_line_status r;
        logic [CMD_BITS-1:0] w;
        int lvl;
        r.accepted = 1'b0;
        if (it.kind == KIND_TICK) begin
            if (m_phase != F_IDLE) begin
                if (m_timer <= 1)
                    advance_frame();
                else
                    m_timer = m_timer - TICK_W'(1);
            end
        end else if ((it.kind == KIND_PLAY || it.kind == KIND_VOLUME) && m_phase == F_IDLE) begin
            if (it.kind == KIND_PLAY) begin
                w = it.value[CMD_BITS-1:0];
            end else begin
                lvl = int'(it.value);
                if (lvl < 0)
                    lvl = 0;
                else if (lvl > int'(VOLUME_MAX))
                    lvl = int'(VOLUME_MAX);
                w = VOLUME_BASE + CMD_BITS'(lvl);
            end
            m_word = {w[7:0], w[15:8]};
            m_bits = '0;
            load_phase(F_LEAD_HIGH, 1'b1, timing.lead_high);
            r.accepted = 1'b1;
            frames_started++;
        end
        r.line_level = m_line;
        r.sending    = (m_phase != F_IDLE);
        r.chip_busy  = it.busy;
        return r;
    endfunction

    task automatic send_cmd(input t_cmd_item it, input bit has_exp = 1'b0,
                            input t_line_status exp = '0);
        t_line_status pred;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.kind          <= it.kind;
        in_if.command_value <= it.value;
        in_if.chip_busy_pin <= it.busy;
        do @(posedge i_clk); while (!in_if.ready);
        pred = predict_line_status(it);
        status_q.push_back(has_exp ? exp : pred);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_LEAD_HIGH: timing.lead_high = data;
            REG_LEAD_LOW:  timing.lead_low  = data;
            REG_GAP_HIGH:  timing.gap_high  = data;
            REG_GAP_LOW:   timing.gap_low   = data;
            REG_SHORT:     timing.short_len = data;
            REG_LONG:      timing.long_len  = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_pace(input t_pace p);
        case (p)
            PACE_FULL:        begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            PACE_SRC_GAPS:    begin src_idle_pct = 53; sink_stall_pct = 0;  end
            PACE_SINK_STALLS: begin src_idle_pct = 0;  sink_stall_pct = 53; end
            default:          begin src_idle_pct = 19; sink_stall_pct = 19; end
        endcase
    endtask

    function automatic t_plan_row item_row(logic [KIND_W-1:0] kind, int value, logic busy,
                                           int reps, bit has_exp, t_line_status exp);
        t_plan_row r;
        r.op       = ROW_ITEM;
        r.it.kind  = kind;
        r.it.value = VALUE_W'(value);
        r.it.busy  = busy;
        r.reps     = reps;
        r.has_exp  = has_exp;
        r.exp      = exp;
        r.reg_idx  = '0;
        r.reg_data = '0;
        return r;
    endfunction

    function automatic t_plan_row reg_row(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] data);
        t_plan_row r;
        r = item_row(KIND_TICK, 0, 1'b0, 0, 1'b0, '0);
        r.op       = ROW_REG;
        r.reg_idx  = idx;
        r.reg_data = data;
        return r;
    endfunction

    function automatic logic [TICK_W-1:0] rand_ticks();
        int p;
        p = $urandom_range(0, 99);
        if (p < 20) return '0;
        if (p < 80) return TICK_W'($urandom_range(1, 2));
        return TICK_W'($urandom_range(3, 5));
    endfunction

    function automatic t_cmd_item rand_tick();
        t_cmd_item it;
        it.kind  = KIND_TICK;
        it.value = VALUE_W'($urandom_range(0, 17'h1FFFF));
        it.busy  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic t_cmd_item rand_command();
        t_cmd_item it;
        int p;
        it = rand_tick();
        it.kind = $urandom_range(0, 1) ? KIND_PLAY : KIND_VOLUME;
        if (it.kind == KIND_VOLUME) begin
            p = $urandom_range(0, 99);
            if (p < 50)
                it.value = VALUE_W'(int'($urandom_range(0, 22)) - 4);
            else if (p < 60)
                it.value = $urandom_range(0, 1) ? 17'sh10000 : 17'sh0FFFF;
        end
        return it;
    endfunction

    initial begin
        t_cmd_item it;
        int n;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_data          = '0;
        in_if.valid         = 1'b0;
        in_if.kind          = KIND_TICK;
        in_if.command_value = '0;
        in_if.chip_busy_pin = 1'b0;
        out_if.ready        = 1'b0;
        sink_hold_request   = 0;
        sink_hold_left      = 0;
        cycles              = 0;
        mismatches          = 0;
        results_checked     = 0;
        items_sent          = 0;
        frames_started      = 0;
        settings_used       = 1;
        hold_done           = 1'b0;
        timing = '{RST_LEAD_HIGH, RST_LEAD_LOW, RST_GAP_HIGH, RST_GAP_LOW, RST_SHORT, RST_LONG};
        m_word  = '0;
        m_phase = F_IDLE;
        m_bits  = '0;
        m_timer = '0;
        m_line  = 1'b1;
        set_pace(PACE_FULL);

        // expected status bits: line, sending, accepted, busy
        plan.push_back(item_row(KIND_TICK,    0,       1'b0, 1, 1'b1, 4'b1000));
        plan.push_back(item_row(KIND_TICK,    0,       1'b1, 1, 1'b1, 4'b1001));
        plan.push_back(item_row(KIND_UNUSED,  -1,      1'b0, 1, 1'b1, 4'b1000));
        // short timing so a frame fits in a few dozen ticks, zero acts as one tick
        plan.push_back(reg_row(REG_LEAD_HIGH, 16'd0));
        plan.push_back(reg_row(REG_LEAD_LOW,  16'd1));
        plan.push_back(reg_row(REG_GAP_HIGH,  16'd2));
        plan.push_back(reg_row(REG_GAP_LOW,   16'd0));
        plan.push_back(reg_row(REG_SHORT,     16'd1));
        plan.push_back(reg_row(REG_LONG,      16'd2));
        plan.push_back(item_row(KIND_PLAY,    'h0A55A, 1'b1, 1, 1'b1, 4'b1111));
        plan.push_back(item_row(KIND_VOLUME,  7,       1'b0, 1, 1'b1, 4'b1100));
        plan.push_back(item_row(KIND_PLAY,    0,       1'b1, 1, 1'b1, 4'b1101));
        plan.push_back(item_row(KIND_UNUSED,  0,       1'b0, 1, 1'b1, 4'b1100));
        plan.push_back(item_row(KIND_TICK,    0,       1'b0, FRAME_TICKS, 1'b0, '0));
        plan.push_back(item_row(KIND_VOLUME,  -32768,  1'b0, 1, 1'b1, 4'b1110));
        plan.push_back(item_row(KIND_TICK,    0,       1'b0, FRAME_TICKS, 1'b0, '0));
        plan.push_back(item_row(KIND_VOLUME,  65535,   1'b1, 1, 1'b1, 4'b1111));
        plan.push_back(item_row(KIND_TICK,    0,       1'b0, FRAME_TICKS, 1'b0, '0));
        // play code with bit 16 set: only the low 16 bits go out
        plan.push_back(item_row(KIND_PLAY,    -65536,  1'b0, 1, 1'b1, 4'b1110));
        plan.push_back(item_row(KIND_TICK,    0,       1'b0, FRAME_TICKS, 1'b0, '0));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].op == ROW_REG) begin
                wait_idle();
                write_reg(plan[r].reg_idx, plan[r].reg_data);
                if (r + 1 < plan.size() && plan[r + 1].op != ROW_REG)
                    settings_used++;
            end else begin
                it = plan[r].it;
                for (int k = 0; k < plan[r].reps; k++) begin
                    // long tick runs get a random busy bit
                    if (plan[r].reps > 1)
                        it.busy = 1'($urandom_range(0, 1));
                    send_cmd(it, plan[r].has_exp, plan[r].exp);
                end
            end
        end

        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            wait_idle();
            set_pace(t_pace'(round % 4));
            for (int idx = 0; idx <= int'(REG_LONG); idx++)
                write_reg(CFG_IDX_W'(idx), (round == 3) ? '0 : rand_ticks());
            settings_used++;
            n = 0;
            while (n < ROUND_ITEMS) begin
                if ($urandom_range(0, 99) < 80) begin
                    send_cmd(rand_command());
                    n++;
                    while (m_phase != F_IDLE) begin
                        if (round == 0 && n >= 30 && !hold_done) begin
                            sink_hold_request = SINK_HOLD;
                            hold_done = 1'b1;
                        end
                        if ($urandom_range(0, 99) < 8) begin
                            it = rand_tick();
                            it.kind = KIND_W'($urandom_range(1, 3));
                        end else begin
                            it = rand_tick();
                        end
                        send_cmd(it);
                        n++;
                    end
                    repeat ($urandom_range(0, 2)) send_cmd(rand_tick());
                end else begin
                    it = rand_tick();
                    it.kind = KIND_W'($urandom_range(0, 3));
                    send_cmd(it);
                    n++;
                end
            end
        end

        wait_idle();
        mismatches += status_q.size();
        $display("%0d transfers sent, %0d frames started, %0d results checked",
                 items_sent, frames_started, results_checked);
        $display("%0d timing settings used, %0d cycles run", settings_used, cycles);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
src/owps_pkg.sv
src/owps_in_if.sv
src/owps_out_if.sv
src/owps_cfg_regs.sv
src/one_wire_pulse_width_sender.sv
tb/sv/tb.sv
